[src/hedd_pkg.sv]
`timescale 1ns / 1ps

package hedd_pkg;

    // register word index, taken from paddr[3:2]
    localparam logic [1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [7:0]  THRESHOLD_RST    = 8'd128;
    localparam logic [11:0] IMAGE_WIDTH_RST  = 12'd640;
    localparam logic [15:0] IMAGE_HEIGHT_RST = 16'd480;

    localparam int NUM_CHAN_PORTS = 4;
    localparam int PIX_W          = 8;
    localparam int ADDR_W         = 4;
    localparam int DATA_W         = 32;

    localparam logic [7:0] PIX_BLACK = 8'd0;
    localparam logic [7:0] PIX_WHITE = 8'd255;

    typedef logic [PIX_W-1:0] pix_t;

    // binarised value and floored half error of one channel
    typedef struct packed {
        pix_t o;
        pix_t half;
    } chan_res_t;

endpackage

[src/half_error_diffusion_dither.sv]
`timescale 1ns / 1ps

// an accepted word is held in the compute stage, then its result in the output register,
//   where it waits while m_ready is low
// throughput: one pixel per cycle while m_ready takes the output, set by the left error
//   loop in the compute stage and the one read plus one write per pixel on the line store
// reset (aresetn, synchronous, active low): registers back to 128 / 640 / 480, counters,
//   left error and pipeline valids cleared; the line store itself is not cleared
module half_error_diffusion_dither #(
    parameter int MAX_WIDTH = 2048,
    parameter int CHANNELS  = 4
) (
    input  logic                             aclk,
    input  logic                             aresetn,

    // configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hedd_pkg::ADDR_W-1:0]      paddr,
    input  logic [hedd_pkg::DATA_W-1:0]      pwdata,
    output logic [hedd_pkg::DATA_W-1:0]      prdata,
    output logic                             pready,

    // pixel input
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [7:0]                       s_chan0_in,
    input  logic [7:0]                       s_chan1_in,
    input  logic [7:0]                       s_chan2_in,
    input  logic [7:0]                       s_chan3_in,

    // dithered output
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [7:0]                       m_chan0_out,
    output logic [7:0]                       m_chan1_out,
    output logic [7:0]                       m_chan2_out,
    output logic [7:0]                       m_chan3_out,
    output logic                             m_row_end,
    output logic                             m_frame_end
);

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int CMP_W = (CW + 1 > 12) ? CW + 1 : 12;
    localparam int MEM_W = CHANNELS * hedd_pkg::PIX_W;
    localparam int NCH   = hedd_pkg::NUM_CHAN_PORTS;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  threshold_reg;
    logic [11:0] image_width_reg;
    logic [15:0] image_height_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg    <= hedd_pkg::THRESHOLD_RST;
            image_width_reg  <= hedd_pkg::IMAGE_WIDTH_RST;
            image_height_reg <= hedd_pkg::IMAGE_HEIGHT_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                hedd_pkg::REG_THRESHOLD:    threshold_reg    <= pwdata[7:0];
                hedd_pkg::REG_IMAGE_WIDTH:  image_width_reg  <= pwdata[11:0];
                hedd_pkg::REG_IMAGE_HEIGHT: image_height_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            hedd_pkg::REG_THRESHOLD:    prdata = {24'd0, threshold_reg};
            hedd_pkg::REG_IMAGE_WIDTH:  prdata = {20'd0, image_width_reg};
            hedd_pkg::REG_IMAGE_HEIGHT: prdata = {16'd0, image_height_reg};
            default:                    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // handshake between input, compute stage and output register
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic m_valid_reg;
    logic s1_move;
    logic s_fire;

    // compute stage hands its word on when the output register is empty or being taken
    assign s1_move = s1_valid_reg & (~m_valid_reg | m_ready);
    assign s_ready = ~s1_valid_reg | s1_move;
    assign s_fire  = s_valid & s_ready;
    assign m_valid = m_valid_reg;

    // ------------------------------------------------------------------
    // raster counters, advanced as each word is accepted
    // ------------------------------------------------------------------
    logic [CW-1:0] col_reg;
    logic [15:0]   row_reg;
    logic          row_end_now;
    logic          frame_end_now;

    // a width of zero ends every row; a width beyond the store ends at its last column
    assign row_end_now = (CMP_W'(col_reg) + CMP_W'(1) >= CMP_W'(image_width_reg))
                       | (col_reg == CW'(MAX_WIDTH - 1));
    assign frame_end_now = row_end_now & ({1'b0, row_reg} + 17'd1 >= {1'b0, image_height_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (s_fire) begin
            if (row_end_now) begin
                col_reg <= '0;
                row_reg <= frame_end_now ? 16'd0 : row_reg + 16'd1;
            end else begin
                col_reg <= col_reg + CW'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // line store: one word of half errors per column
    // read as the pixel is accepted, written back as it leaves the compute stage
    // ------------------------------------------------------------------
    logic [MEM_W-1:0] line_mem [MAX_WIDTH];
    logic [MEM_W-1:0] above_reg;
    logic [MEM_W-1:0] half_next;
    logic [CW-1:0]    s1_col_reg;

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            line_mem[s1_col_reg] <= half_next;
        end
    end

    // forward the word being written when the next pixel reads the same column (width zero or one)
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            if (s1_move && (s1_col_reg == col_reg)) begin
                above_reg <= half_next;
            end else begin
                above_reg <= line_mem[col_reg];
            end
        end
    end

    // ------------------------------------------------------------------
    // compute stage registers
    // ------------------------------------------------------------------
    logic [7:0] in_pix [NCH];
    logic [7:0] pix_reg [CHANNELS];
    logic       s1_first_row_reg;
    logic       s1_first_col_reg;
    logic       s1_row_end_reg;
    logic       s1_frame_end_reg;

    assign in_pix[0] = s_chan0_in;
    assign in_pix[1] = s_chan1_in;
    assign in_pix[2] = s_chan2_in;
    assign in_pix[3] = s_chan3_in;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_fire) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_move) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            for (int c = 0; c < CHANNELS; c++) begin
                pix_reg[c] <= in_pix[c];
            end
            s1_col_reg       <= col_reg;
            s1_first_row_reg <= (row_reg == 16'd0);
            s1_first_col_reg <= (col_reg == '0);
            s1_row_end_reg   <= row_end_now;
            s1_frame_end_reg <= frame_end_now;
        end
    end

    // ------------------------------------------------------------------
    // per channel: add error from above (not on the first row), clamp, add error from the left
    // (not on the first column), clamp, threshold, then floor the halved quantisation error
    // ------------------------------------------------------------------
    function automatic logic [7:0] clamp_add(input logic [7:0] v, input logic [7:0] e);
        logic [9:0] sum;
        sum = {2'b00, v} + {{2{e[7]}}, e};
        if (sum[9]) begin
            clamp_add = hedd_pkg::PIX_BLACK;
        end else if (sum[8]) begin
            clamp_add = hedd_pkg::PIX_WHITE;
        end else begin
            clamp_add = sum[7:0];
        end
    endfunction

    function automatic hedd_pkg::chan_res_t dither_chan(
        input logic [7:0] pix,
        input logic [7:0] above,
        input logic [7:0] left,
        input logic       use_above,
        input logic       use_left,
        input logic [7:0] thr
    );
        logic [7:0]        v_a;
        logic [7:0]        v_b;
        logic [7:0]        o;
        logic [9:0]        err;
        hedd_pkg::chan_res_t r;
        v_a    = use_above ? clamp_add(pix, above) : pix;
        v_b    = use_left ? clamp_add(v_a, left) : v_a;
        o      = (v_b < thr) ? hedd_pkg::PIX_BLACK : hedd_pkg::PIX_WHITE;
        err    = {2'b00, v_b} - {2'b00, o};
        r.o    = o;
        r.half = err[8:1];
        dither_chan = r;
    endfunction

    logic [MEM_W-1:0] left_error_reg;
    logic [7:0]       res_chan [NCH];

    always_comb begin
        hedd_pkg::chan_res_t r;
        half_next = '0;
        for (int c = 0; c < NCH; c++) begin
            res_chan[c] = hedd_pkg::PIX_BLACK;
        end
        for (int c = 0; c < CHANNELS; c++) begin
            r = dither_chan(pix_reg[c],
                            above_reg[c*8 +: 8],
                            left_error_reg[c*8 +: 8],
                            ~s1_first_row_reg,
                            ~s1_first_col_reg,
                            threshold_reg);
            res_chan[c]         = r.o;
            half_next[c*8 +: 8] = r.half;
        end
    end

    // left error is registered here and loops back to the next pixel
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_error_reg <= '0;
        end else if (s1_move) begin
            left_error_reg <= half_next;
        end
    end

    // ------------------------------------------------------------------
    // output register
    // ------------------------------------------------------------------
    logic [7:0] out_chan_reg [NCH];
    logic       row_end_reg;
    logic       frame_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_move) begin
            for (int c = 0; c < NCH; c++) begin
                out_chan_reg[c] <= res_chan[c];
            end
            row_end_reg   <= s1_row_end_reg;
            frame_end_reg <= s1_frame_end_reg;
        end
    end

    assign m_chan0_out = out_chan_reg[0];
    assign m_chan1_out = out_chan_reg[1];
    assign m_chan2_out = out_chan_reg[2];
    assign m_chan3_out = out_chan_reg[3];
    assign m_row_end   = row_end_reg;
    assign m_frame_end = frame_end_reg;

endmodule
